>>> rtl/core/stepper_microstep_step_generator_defines.svh
// ----------------------------------------------------------------------------
// Stepper microstep generator: assertion macros
// Shared concurrent assertion helpers for the generator RTL.
// ----------------------------------------------------------------------------
`ifndef STEPPER_MICROSTEP_STEP_GENERATOR_DEFINES_SVH
`define STEPPER_MICROSTEP_STEP_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SMDRV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smdrv assertion failed");

// Next-cycle implication, disabled while in reset
`define SMDRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smdrv assertion failed");

`endif

>>> rtl/core/smdrv_pkg.sv
// ----------------------------------------------------------------------------
// smdrv_pkg
// Types, constants and the sine level table of the stepper step generator.
// ----------------------------------------------------------------------------
package smdrv_pkg;

	// Command codes
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_MOVE_AB = 3'd1;
	localparam logic [2:0] CMD_MOVE_RL = 3'd2;
	localparam logic [2:0] CMD_STOP    = 3'd3;
	localparam logic [2:0] CMD_SET_POS = 3'd4;

	// Register indexes
	localparam logic REG_MIN_DELAY = 1'b0;
	localparam logic REG_ON_THRESH = 1'b1;

	// Register reset values
	localparam logic [15:0] MIN_DELAY_RST  = 16'd100;
	localparam logic [7:0]  ON_THRESH_RST  = 8'd128;
	localparam logic [15:0] STEP_DELAY_RST = 16'd1000;

	// Step period divider: 1000000 / speed
	localparam int          DIV_STEPS    = 20;
	localparam int          DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam logic [DIV_STEPS-1:0] DIV_DIVIDEND = 20'd1000000;

	// Sine table
	localparam int TABLE_ENTRIES = 64;
	localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES);

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// Levels per entry, line 3 in the top byte, line 0 in the low byte
	localparam logic [31:0] SINE_LEVELS [TABLE_ENTRIES] = '{
		{8'd0, 8'd0, 8'd0, 8'd255}, {8'd0, 8'd0, 8'd25, 8'd255},
		{8'd0, 8'd0, 8'd50, 8'd255}, {8'd0, 8'd0, 8'd74, 8'd255},
		{8'd0, 8'd0, 8'd98, 8'd255}, {8'd0, 8'd0, 8'd120, 8'd255},
		{8'd0, 8'd0, 8'd142, 8'd255}, {8'd0, 8'd0, 8'd162, 8'd255},
		{8'd0, 8'd0, 8'd180, 8'd255}, {8'd0, 8'd0, 8'd197, 8'd255},
		{8'd0, 8'd0, 8'd212, 8'd255}, {8'd0, 8'd0, 8'd226, 8'd255},
		{8'd0, 8'd0, 8'd238, 8'd255}, {8'd0, 8'd0, 8'd248, 8'd255},
		{8'd0, 8'd0, 8'd254, 8'd255}, {8'd0, 8'd0, 8'd255, 8'd255},
		{8'd0, 8'd0, 8'd255, 8'd254}, {8'd0, 8'd0, 8'd255, 8'd248},
		{8'd0, 8'd0, 8'd255, 8'd238}, {8'd0, 8'd0, 8'd255, 8'd226},
		{8'd0, 8'd0, 8'd255, 8'd212}, {8'd0, 8'd0, 8'd255, 8'd197},
		{8'd0, 8'd0, 8'd255, 8'd180}, {8'd0, 8'd0, 8'd255, 8'd162},
		{8'd0, 8'd0, 8'd255, 8'd142}, {8'd0, 8'd0, 8'd255, 8'd120},
		{8'd0, 8'd0, 8'd255, 8'd98}, {8'd0, 8'd0, 8'd255, 8'd74},
		{8'd0, 8'd0, 8'd255, 8'd50}, {8'd0, 8'd0, 8'd255, 8'd25},
		{8'd0, 8'd0, 8'd255, 8'd0}, {8'd0, 8'd25, 8'd255, 8'd0},
		{8'd0, 8'd50, 8'd254, 8'd0}, {8'd0, 8'd74, 8'd248, 8'd0},
		{8'd0, 8'd98, 8'd238, 8'd0}, {8'd0, 8'd120, 8'd226, 8'd0},
		{8'd0, 8'd142, 8'd212, 8'd0}, {8'd0, 8'd162, 8'd197, 8'd0},
		{8'd0, 8'd180, 8'd180, 8'd0}, {8'd0, 8'd197, 8'd162, 8'd0},
		{8'd0, 8'd212, 8'd142, 8'd0}, {8'd0, 8'd226, 8'd120, 8'd0},
		{8'd0, 8'd238, 8'd98, 8'd0}, {8'd0, 8'd248, 8'd74, 8'd0},
		{8'd0, 8'd254, 8'd50, 8'd0}, {8'd0, 8'd255, 8'd25, 8'd0},
		{8'd0, 8'd255, 8'd0, 8'd0}, {8'd25, 8'd255, 8'd0, 8'd0},
		{8'd50, 8'd254, 8'd0, 8'd0}, {8'd74, 8'd248, 8'd0, 8'd0},
		{8'd98, 8'd238, 8'd0, 8'd0}, {8'd120, 8'd226, 8'd0, 8'd0},
		{8'd142, 8'd212, 8'd0, 8'd0}, {8'd162, 8'd197, 8'd0, 8'd0},
		{8'd180, 8'd180, 8'd0, 8'd0}, {8'd197, 8'd162, 8'd0, 8'd0},
		{8'd212, 8'd142, 8'd0, 8'd0}, {8'd226, 8'd120, 8'd0, 8'd0},
		{8'd238, 8'd98, 8'd0, 8'd0}, {8'd248, 8'd74, 8'd0, 8'd0},
		{8'd254, 8'd50, 8'd0, 8'd0}, {8'd255, 8'd25, 8'd0, 8'd0},
		{8'd255, 8'd0, 8'd0, 8'd0}, {8'd255, 8'd0, 8'd0, 8'd25}
	};

	// Phase lines for one table entry: a line is on when its level exceeds thr
	function automatic logic [3:0] phase_lines(input logic [TBL_IDX_W-1:0] idx,
			input logic [7:0] thr);
		logic [31:0] row;
		logic [3:0]  res;
		row = SINE_LEVELS[idx];
		for (int k = 0; k < 4; k++) begin
			res[k] = (row[8*k +: 8] > thr);
		end
		return res;
	endfunction

endpackage

>>> rtl/core/stepper_microstep_step_generator.sv
// ----------------------------------------------------------------------------
// stepper_microstep_step_generator
// Two-phase stepper microstep generator: ticks, moves, stop and set-position
// commands drive a position counter and sine-table phase lines.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Contents
// s_axis    in   tvalid/tready          one command word
// m_axis    out  tvalid/tready          one status word per command
// cfg       in   cfg_we                 min step delay, on threshold
//
// Moves with a nonzero speed wait for the 20-step divider; ticks, stops, set
// position and zero-speed moves do not use it. Result leaves through an
// output register.
// Reset clears all control state and positions; no clearing pass.
// A stalled output holds the next command in the done state.
// ----------------------------------------------------------------------------
`include "stepper_microstep_step_generator_defines.svh"

module stepper_microstep_step_generator
	import smdrv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] position_value, [47:32] step_rate, [48] hold, [55:49] zero
	input  logic [55:0] s_axis_tdata,
	// [2:0] command
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] phase_a_plus, [1] phase_b_plus, [2] phase_a_minus, [3] phase_b_minus,
	// [35:4] position_now, [36] running, [37] reached, [39:38] zero
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MOVE  = 3'd3;
	localparam logic [2:0] ST_STEP  = 3'd4;
	localparam logic [2:0] ST_LINES = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  cmd_q;
	logic [31:0] val_q;
	logic [15:0] speed_q;
	logic        hold_q;

	logic [15:0] min_delay_q;
	logic [7:0]  on_thr_q;

	logic [31:0] pos_q;
	logic [31:0] target_q;
	logic [15:0] delay_q;
	logic [15:0] period_q;
	logic        moving_q;
	logic [3:0]  phase_q;
	logic        hit_q;

	logic        out_valid_q;
	logic [39:0] out_data_q;

	logic              div_start;
	div_status_t       div_st;
	logic [DIV_STEPS-1:0] div_quo;
	logic [15:0]       sat_delay;
	logic [15:0]       new_delay;
	logic [16:0]       period_inc;
	logic              out_free;
	logic              accept;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign div_start     = (state_q == ST_EXEC) &&
		((cmd_q == CMD_MOVE_AB) || (cmd_q == CMD_MOVE_RL)) && (speed_q != 16'd0);

	// Step period: saturate the quotient, then clamp at the minimum
	assign sat_delay  = (div_quo[DIV_STEPS-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
	assign new_delay  = (sat_delay < min_delay_q) ? min_delay_q : sat_delay;
	assign period_inc = {1'b0, period_q} + 17'd1;

	smdrv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (speed_q),
		.status   (div_st),
		.quotient (div_quo)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= MIN_DELAY_RST;
			on_thr_q    <= ON_THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_DELAY: min_delay_q <= cfg_data;
				REG_ON_THRESH: on_thr_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_axis_tuser;
			val_q   <= s_axis_tdata[31:0];
			speed_q <= s_axis_tdata[47:32];
			hold_q  <= s_axis_tdata[48];
		end
	end

	// Sequencer and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			target_q <= '0;
			delay_q  <= STEP_DELAY_RST;
			period_q <= '0;
			moving_q <= 1'b0;
			phase_q  <= '0;
			hit_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					hit_q <= 1'b0;
					case (cmd_q)
						CMD_TICK: begin
							if (moving_q) begin
								if (period_inc >= {1'b0, delay_q}) begin
									period_q <= '0;
									state_q  <= ST_STEP;
								end else begin
									period_q <= period_inc[15:0];
									state_q  <= ST_DONE;
								end
							end else begin
								state_q <= ST_DONE;
							end
						end
						CMD_MOVE_AB, CMD_MOVE_RL: begin
							target_q <= (cmd_q == CMD_MOVE_AB) ? val_q : pos_q + val_q;
							period_q <= '0;
							state_q  <= (speed_q != 16'd0) ? ST_DIV : ST_MOVE;
						end
						CMD_STOP: begin
							moving_q <= 1'b0;
							period_q <= '0;
							if (!hold_q) begin
								phase_q <= '0;
							end
							state_q  <= ST_DONE;
						end
						CMD_SET_POS: begin
							moving_q <= 1'b0;
							period_q <= '0;
							phase_q  <= '0;
							pos_q    <= val_q;
							target_q <= val_q;
							state_q  <= ST_DONE;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_DIV: begin
					if (div_st.done) begin
						delay_q <= new_delay;
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					moving_q <= (pos_q != target_q);
					state_q  <= ST_DONE;
				end
				ST_STEP: begin
					// signed direction toward the target
					if ($signed(target_q) > $signed(pos_q)) begin
						pos_q <= pos_q + 32'd1;
					end else begin
						pos_q <= pos_q - 32'd1;
					end
					state_q <= ST_LINES;
				end
				ST_LINES: begin
					phase_q <= phase_lines(pos_q[TBL_IDX_W-1:0], on_thr_q);
					if (pos_q == target_q) begin
						moving_q <= 1'b0;
						hit_q    <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {2'b00, hit_q, moving_q, pos_q, phase_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Checks
	`SMDRV_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, accept, !s_axis_tready)
	`SMDRV_ASSERT_NOW(a_div_in_div_state, clk, arst_n, div_st.busy, state_q == ST_DIV)
	`SMDRV_ASSERT_NOW(a_reached_stops, clk, arst_n,
		m_axis_tvalid && m_axis_tdata[37], !m_axis_tdata[36])

endmodule

>>> rtl/core/smdrv_div.sv
// ----------------------------------------------------------------------------
// smdrv_div
// Restoring radix-2 divider: 1000000 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smdrv_div
	import smdrv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [15:0]          divisor,
	output div_status_t          status,
	output logic [DIV_STEPS-1:0] quotient
);

	logic [15:0]          div_q;
	logic [15:0]          rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [16:0]          trial;
	logic                 fits;
	logic [16:0]          diff;

	// One shift-subtract step
	assign trial = {rem_q, quo_q[DIV_STEPS-1]};
	assign fits  = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= DIV_DIVIDEND;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[DIV_STEPS-2:0], fits};
		end
	end

	assign status   = '{busy: busy_q, done: done_q};
	assign quotient = quo_q;

endmodule

>>> bench/motor_status_checker.sv
// ----------------------------------------------------------------------------
// motor_status_checker
// Watches the command, status and register ports of the step generator. It
// keeps its own copy of the motor state, predicts one status word for every
// accepted command, and compares each accepted status word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_status_checker
	import smdrv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// [31:0] position_value, [47:32] step_rate, [48] hold, [55:49] zero
	input  logic [55:0] s_axis_tdata,
	// [2:0] command
	input  logic [2:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] phase lines a+, b+, a-, b-, [35:4] position_now, [36] running,
	// [37] reached, [39:38] zero
	input  logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          status_pending
);

	typedef struct packed {
		logic [3:0]  lines;
		logic [31:0] pos;
		logic        running;
		logic        reached;
	} motor_status_t;

	// Predicted motor state and register copies
	logic [31:0] mot_pos     = '0;
	logic [31:0] mot_target  = '0;
	logic [15:0] mot_delay   = 16'd1000;
	logic [15:0] mot_count   = '0;
	logic        mot_moving  = 1'b0;
	logic [3:0]  mot_lines   = '0;
	logic [15:0] reg_min_delay = 16'd100;
	logic [7:0]  reg_threshold = 8'd128;

	motor_status_t status_due [$];

	// Sine levels per table entry: line 0 in the top byte, line 3 in the low byte
	function automatic logic [31:0] sine_row(input logic [5:0] idx);
		logic [31:0] r;
		r = '0;
		case (idx)
			6'd0:  r = 32'hFF000000;  6'd1:  r = 32'hFF190000;  6'd2:  r = 32'hFF320000;
			6'd3:  r = 32'hFF4A0000;  6'd4:  r = 32'hFF620000;  6'd5:  r = 32'hFF780000;
			6'd6:  r = 32'hFF8E0000;  6'd7:  r = 32'hFFA20000;  6'd8:  r = 32'hFFB40000;
			6'd9:  r = 32'hFFC50000;  6'd10: r = 32'hFFD40000;  6'd11: r = 32'hFFE20000;
			6'd12: r = 32'hFFEE0000;  6'd13: r = 32'hFFF80000;  6'd14: r = 32'hFFFE0000;
			6'd15: r = 32'hFFFF0000;  6'd16: r = 32'hFEFF0000;  6'd17: r = 32'hF8FF0000;
			6'd18: r = 32'hEEFF0000;  6'd19: r = 32'hE2FF0000;  6'd20: r = 32'hD4FF0000;
			6'd21: r = 32'hC5FF0000;  6'd22: r = 32'hB4FF0000;  6'd23: r = 32'hA2FF0000;
			6'd24: r = 32'h8EFF0000;  6'd25: r = 32'h78FF0000;  6'd26: r = 32'h62FF0000;
			6'd27: r = 32'h4AFF0000;  6'd28: r = 32'h32FF0000;  6'd29: r = 32'h19FF0000;
			6'd30: r = 32'h00FF0000;  6'd31: r = 32'h00FF1900;  6'd32: r = 32'h00FE3200;
			6'd33: r = 32'h00F84A00;  6'd34: r = 32'h00EE6200;  6'd35: r = 32'h00E27800;
			6'd36: r = 32'h00D48E00;  6'd37: r = 32'h00C5A200;  6'd38: r = 32'h00B4B400;
			6'd39: r = 32'h00A2C500;  6'd40: r = 32'h008ED400;  6'd41: r = 32'h0078E200;
			6'd42: r = 32'h0062EE00;  6'd43: r = 32'h004AF800;  6'd44: r = 32'h0032FE00;
			6'd45: r = 32'h0019FF00;  6'd46: r = 32'h0000FF00;  6'd47: r = 32'h0000FF19;
			6'd48: r = 32'h0000FE32;  6'd49: r = 32'h0000F84A;  6'd50: r = 32'h0000EE62;
			6'd51: r = 32'h0000E278;  6'd52: r = 32'h0000D48E;  6'd53: r = 32'h0000C5A2;
			6'd54: r = 32'h0000B4B4;  6'd55: r = 32'h0000A2C5;  6'd56: r = 32'h00008ED4;
			6'd57: r = 32'h000078E2;  6'd58: r = 32'h000062EE;  6'd59: r = 32'h00004AF8;
			6'd60: r = 32'h000032FE;  6'd61: r = 32'h000019FF;  6'd62: r = 32'h000000FF;
			6'd63: r = 32'h190000FF;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Advance the motor state by one command and return the status it shows
	function automatic motor_status_t next_motor_status(input logic [2:0] cmd,
			input logic [31:0] val, input logic [15:0] speed, input logic hold);
		motor_status_t st;
		logic [31:0]   quot;
		logic [31:0]   row;
		st.reached = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (mot_moving) begin
					if (mot_count + 32'd1 >= {16'd0, mot_delay}) begin
						mot_count = '0;
						if ($signed(mot_target) > $signed(mot_pos))
							mot_pos = mot_pos + 32'd1;
						else
							mot_pos = mot_pos - 32'd1;
						row = sine_row(mot_pos[5:0]);
						for (int k = 0; k < 4; k++)
							mot_lines[k] = (row[31-8*k -: 8] > reg_threshold);
						if (mot_pos == mot_target) begin
							mot_moving = 1'b0;
							st.reached = 1'b1;
						end
					end else begin
						mot_count = mot_count + 16'd1;
					end
				end
			end
			CMD_MOVE_AB, CMD_MOVE_RL: begin
				mot_target = (cmd == CMD_MOVE_AB) ? val : mot_pos + val;
				// zero speed keeps the old period
				if (speed != 16'd0) begin
					quot = 32'd1000000 / {16'd0, speed};
					if (quot > 32'd65535) quot = 32'd65535;
					if (quot < {16'd0, reg_min_delay}) quot = {16'd0, reg_min_delay};
					mot_delay = quot[15:0];
				end
				mot_count = '0;
				mot_moving = (mot_pos != mot_target);
			end
			CMD_STOP: begin
				mot_moving = 1'b0;
				mot_count = '0;
				if (!hold) mot_lines = '0;
			end
			CMD_SET_POS: begin
				mot_moving = 1'b0;
				mot_count = '0;
				mot_lines = '0;
				mot_pos = val;
				mot_target = val;
			end
			default: begin
			end
		endcase
		st.lines = mot_lines;
		st.pos = mot_pos;
		st.running = mot_moving;
		return st;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Register copies, status comparison and prediction on each accepted word
	always @(posedge clk or negedge arst_n) begin
		motor_status_t want;
		motor_status_t got;
		if (!arst_n) begin
			mot_pos = '0;
			mot_target = '0;
			mot_delay = 16'd1000;
			mot_count = '0;
			mot_moving = 1'b0;
			mot_lines = '0;
			reg_min_delay = 16'd100;
			reg_threshold = 8'd128;
			status_due.delete();
			mismatch_count = 0;
			status_pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MIN_DELAY)
					reg_min_delay = cfg_data;
				else
					reg_threshold = cfg_data[7:0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.lines = m_axis_tdata[3:0];
				got.pos = m_axis_tdata[35:4];
				got.running = m_axis_tdata[36];
				got.reached = m_axis_tdata[37];
				if (status_due.size() == 0) begin
					$display("%0t: status word with nothing pending, expected none got %h",
						$time, m_axis_tdata);
					mismatch_count++;
				end else begin
					want = status_due.pop_front();
					check_field("phase_a_plus", want.lines[0], got.lines[0]);
					check_field("phase_b_plus", want.lines[1], got.lines[1]);
					check_field("phase_a_minus", want.lines[2], got.lines[2]);
					check_field("phase_b_minus", want.lines[3], got.lines[3]);
					check_field("position_now", want.pos, got.pos);
					check_field("running", want.running, got.running);
					check_field("reached", want.reached, got.reached);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				status_due.push_back(next_motor_status(s_axis_tuser, s_axis_tdata[31:0],
					s_axis_tdata[47:32], s_axis_tdata[48]));
			status_pending = status_due.size();
		end
	end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the stepper step generator: directed commands at the register
// extremes, then phases of random motion bursts (set position, move, ticks,
// stops) and noise words under varying register settings and flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import smdrv_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [31:0] position_value, [47:32] step_rate, [48] hold, [55:49] zero
	logic [55:0] s_axis_tdata  = '0;
	// [2:0] command
	logic [2:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [3:0] phase lines, [35:4] position_now, [36] running, [37] reached
	logic [39:0] m_axis_tdata;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = 1'b0;
	logic [15:0] cfg_data      = '0;

	int mismatch_count;
	int status_pending;
	int words_sent  = 0;
	int sidle_pct   = 0;
	int rstall_pct  = 0;
	int cur_min     = 100;

	stepper_microstep_step_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	motor_status_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.status_pending(status_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random backpressure on the status side
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rstall_pct);
	end

	// Watchdog: cycles in a row with no word moving on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
					(m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One command word; tvalid stays high into the next word unless idling
	task automatic send_word(input logic [2:0] cmd, input logic [31:0] val,
			input logic [15:0] speed, input logic hold);
		@(negedge clk);
		while ($urandom_range(0, 99) < sidle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {7'd0, hold, speed, val};
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	// Hold off the sender until every status word is back
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (status_pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Rough step period for a move, used to size the tick run after it
	function automatic int est_delay(input logic [15:0] speed);
		int d;
		if (speed == 16'd0) return 20;
		d = 1000000 / speed;
		if (d > 65535) d = 65535;
		if (d < cur_min) d = cur_min;
		return d;
	endfunction

	// Mostly a move of a few steps with enough ticks to finish it; some noise
	task automatic run_motion_burst();
		logic [31:0] base;
		logic [31:0] delta;
		logic [15:0] speed;
		int steps;
		int ticks;
		int pace;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 4))
				send_word(3'($urandom_range(0, 7)), $urandom, 16'($urandom),
					1'($urandom_range(0, 1)));
		end else begin
			steps = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);
			delta = $urandom_range(0, 1) ? steps : -steps;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: speed = 16'($urandom_range(50000, 65535));
				6: speed = 16'd0;
				7, 8: speed = 16'($urandom_range(1, 16));
				default: speed = 16'($urandom);
			endcase
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 4))
					0, 1: base = $urandom;
					2: base = 32'h7FFF_FFFF - $urandom_range(0, 3);
					3: base = 32'h8000_0000 + $urandom_range(0, 3);
					default: base = $urandom_range(0, 200) - 100;
				endcase
				send_word(CMD_SET_POS, base, 16'($urandom), 1'($urandom_range(0, 1)));
				send_word(CMD_MOVE_AB, base + delta, speed, 1'($urandom_range(0, 1)));
			end else begin
				send_word(CMD_MOVE_RL, delta, speed, 1'($urandom_range(0, 1)));
			end
			pace = est_delay(speed);
			if (steps != 0 && pace * steps <= 160)
				ticks = pace * steps + $urandom_range(0, 4);
			else
				ticks = $urandom_range(1, 12);
			// sometimes cut the run short
			if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, ticks);
			repeat (ticks) begin
				if ($urandom_range(0, 49) == 0)
					send_word(CMD_MOVE_RL, $urandom_range(0, 4) - 2,
						16'($urandom_range(50000, 65535)), 1'b0);
				else
					send_word(CMD_TICK, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 3) == 0)
				send_word(CMD_STOP, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(input logic [15:0] min_delay, input logic [7:0] thr,
			input int sidle, input int rstall, input int count);
		int stop_at;
		settle();
		write_reg(REG_MIN_DELAY, min_delay);
		write_reg(REG_ON_THRESH, {8'd0, thr});
		cur_min = int'(min_delay);
		sidle_pct = sidle;
		rstall_pct = rstall;
		stop_at = words_sent + count;
		while (words_sent < stop_at) run_motion_burst();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset register values
		send_word(CMD_TICK, 32'd0, 16'd0, 1'b0);                 // tick while idle
		send_word(CMD_MOVE_AB, 32'd0, 16'd1000, 1'b0);           // move onto itself
		send_word(CMD_MOVE_RL, 32'd0, 16'd0, 1'b1);              // zero speed, self
		send_word(CMD_SET_POS, 32'h7FFF_FFFF, 16'hFFFF, 1'b1);
		send_word(CMD_MOVE_RL, 32'd1, 16'd1, 1'b0);              // target wraps, slow
		send_word(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_word(CMD_STOP, 32'd0, 16'd0, 1'b1);
		send_word(CMD_SET_POS, 32'h8000_0000, 16'd0, 1'b0);
		send_word(3'd5, 32'h1234_5678, 16'h00FF, 1'b0);          // unused codes
		send_word(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_word(CMD_MOVE_AB, 32'h8000_0001, 16'd65535, 1'b0);  // clamped to minimum
		send_word(CMD_STOP, 32'd0, 16'd0, 1'b0);

		// Directed, lowest minimum delay: one step that reaches the target
		settle();
		write_reg(REG_MIN_DELAY, 16'd1);
		write_reg(REG_ON_THRESH, 16'd0);
		cur_min = 1;
		send_word(CMD_SET_POS, 32'h7FFF_FFFE, 16'd0, 1'b0);
		send_word(CMD_MOVE_AB, 32'h7FFF_FFFF, 16'd65535, 1'b0);
		repeat (15) send_word(CMD_TICK, 32'd0, 16'd0, 1'b0);
		send_word(CMD_TICK, 32'd0, 16'd0, 1'b0);
		send_word(CMD_STOP, 32'd0, 16'd0, 1'b1);
		send_word(CMD_STOP, 32'd0, 16'd0, 1'b0);

		// Random phases
		run_phase(16'd1, 8'd0, 0, 0, 260);
		run_phase(16'd20, 8'd255, 56, 0, 210);
		run_phase(16'($urandom_range(1, 18)), 8'($urandom), 0, 56, 260);
		run_phase(16'd15, 8'd128, 30, 30, 260);
		run_phase(16'd65535, 8'd200, 30, 30, 60);
		run_phase(16'd100, 8'($urandom), 0, 0, 100);

		settle();
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && status_pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
